// File: hdl/irpps_pkg.sv
// ----------------------------------------------------------------------------
// irpps_pkg
// Shared types, constants and helpers for the IR pulse-pair symbol decoder.
// ----------------------------------------------------------------------------
package irpps_pkg;

  // Field widths
  localparam int unsigned SENSOR_W  = 3;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned SYM_W     = 12;
  localparam int unsigned MINI_W    = 13;
  localparam int unsigned TOL_W     = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DW    = 16;

  // Default sensor count
  localparam int unsigned DEF_NUM_SENSORS = 7;

  // Edges kept per sensor
  localparam int unsigned EDGES   = 4;
  localparam int unsigned EDGE_W  = 2;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Symbol grid
  localparam int unsigned SYM_GAIN         = 28;
  localparam int unsigned SYM_OFFSET       = 7000;
  localparam int unsigned SYM_ROUND_OFFSET = 6986;
  localparam int unsigned MAX_INTENSITY    = 7000;

  // x / 28 == (x >> 2) / 7; /7 by reciprocal, exact for 14-bit operands
  localparam int unsigned DIV_PRE_SHIFT = 2;
  localparam int unsigned QUOT_IN_W     = TIME_W - DIV_PRE_SHIFT;
  localparam int unsigned RECIP_7       = 18725;
  localparam int unsigned RECIP_W       = 15;
  localparam int unsigned RECIP_SHIFT   = 17;
  localparam int unsigned PROD_W        = QUOT_IN_W + RECIP_W;

  // Register reset values
  localparam logic [TIME_W-1:0] RST_WINDOW  = 16'd36;
  localparam logic [MINI_W-1:0] RST_MIN_INT = 13'd1400;
  localparam logic [TOL_W-1:0]  RST_BAL_TOL = 15'd20;
  localparam logic [TOL_W-1:0]  RST_SYM_TOL = 15'd3;

  // Configuration register index
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW  = 2'd0,
    REG_MIN_INT = 2'd1,
    REG_BAL_TOL = 2'd2,
    REG_SYM_TOL = 2'd3
  } cfg_reg_e;

  // Item class from the front
  typedef enum logic [1:0] {
    KIND_EDGE  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_SKIP  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [TIME_W-1:0] window;
    logic [MINI_W-1:0] min_int;
    logic [TOL_W-1:0]  bal_tol;
    logic [TOL_W-1:0]  sym_tol;
  } cfg_t;

  typedef struct packed {
    kind_e               kind;
    logic [SENSOR_W-1:0] sensor;
    logic [TIME_W-1:0]   cap;
    logic [TIME_W-1:0]   tick;
  } item_t;

  // Spacings of a completed, in-window edge quad
  typedef struct packed {
    logic                eval;
    logic [SENSOR_W-1:0] sensor;
    logic [TIME_W-1:0]   intensity;
    logic [TIME_W-1:0]   lead;
    logic [TIME_W-1:0]   trail;
  } meas_t;

  // Magnitude of a 16-bit two's complement difference
  function automatic logic [TIME_W-1:0] mag16(input logic [TIME_W-1:0] d);
    logic [TIME_W-1:0] neg;
    neg = TIME_W'(~d + TIME_W'(1));
    return d[TIME_W-1] ? neg : d;
  endfunction

endpackage

// File: hdl/irpps_front.sv
// ----------------------------------------------------------------------------
// irpps_front
// Accepts input transactions, classifies them and queues them for the back.
// ----------------------------------------------------------------------------
module irpps_front #(
  parameter int unsigned NUM_SENSORS = irpps_pkg::DEF_NUM_SENSORS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           mode_i,
  input  logic [irpps_pkg::SENSOR_W-1:0] sensor_i,
  input  logic [irpps_pkg::TIME_W-1:0]   capture_time_i,
  input  logic [irpps_pkg::TIME_W-1:0]   tick_time_i,
  output logic                           q_valid_o,
  output irpps_pkg::item_t               q_item_o,
  input  logic                           q_pop_i
);
  import irpps_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             fifo_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              push, pop;
  item_t             item;

  // Classify the incoming transaction
  always_comb begin
    item.sensor = sensor_i;
    item.cap    = capture_time_i;
    item.tick   = tick_time_i;
    if (mode_i) begin
      item.kind = KIND_CLEAR;
    end else if (int'(sensor_i) >= NUM_SENSORS) begin
      item.kind = KIND_SKIP;
    end else begin
      item.kind = KIND_EDGE;
    end
  end

  assign in_stall_o = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = fifo_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    if (push && !pop) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill count out of range");

  a_push_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == CNT_W'($past(cnt_q) + 1'b1))
    else $error("queue count did not grow on push");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == CNT_W'($past(cnt_q) - 1'b1))
    else $error("queue count did not shrink on pop");
`endif

endmodule

// File: hdl/irpps_track.sv
// ----------------------------------------------------------------------------
// irpps_track
// Per-sensor edge tracking: the edge rows are read, modified and written back in the same cycle.
// ----------------------------------------------------------------------------
module irpps_track #(
  parameter int unsigned NUM_SENSORS = irpps_pkg::DEF_NUM_SENSORS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  irpps_pkg::cfg_t              cfg_i,
  input  logic                         q_valid_i,
  input  irpps_pkg::item_t             q_item_i,
  output logic                         q_pop_o,
  input  logic                         adv_i,
  output logic                         s1_valid_o,
  output irpps_pkg::meas_t             s1_meas_o
);
  import irpps_pkg::*;

  localparam int unsigned IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  // Edge counts (reset) and edge rows (no reset, written before read)
  logic [NUM_SENSORS-1:0][EDGE_W-1:0] cnt_q, cnt_d;
  logic [TIME_W-1:0]                  cap_q  [NUM_SENSORS][EDGES];
  logic [TIME_W-1:0]                  tick_q [NUM_SENSORS][EDGES];

  logic [TIME_W-1:0] row_cap  [EDGES];
  logic [TIME_W-1:0] row_tick [EDGES];
  logic [TIME_W-1:0] new_cap  [EDGES];
  logic [TIME_W-1:0] new_tick [EDGES];

  logic [IDX_W-1:0]  idx;
  logic [EDGE_W-1:0] cnt_rd;
  logic              pop, is_edge, is_clear, row_we;
  logic [TIME_W-1:0] span;
  logic              in_window;
  logic              s1_valid_q;
  meas_t             s1_meas_q, s1_meas_d;

  assign pop      = q_valid_i && adv_i;
  assign q_pop_o  = pop;
  assign idx      = IDX_W'(q_item_i.sensor);
  assign is_edge  = pop && (q_item_i.kind == KIND_EDGE);
  assign is_clear = pop && (q_item_i.kind == KIND_CLEAR);
  assign cnt_rd   = cnt_q[idx];

  always_comb begin
    for (int k = 0; k < EDGES; k++) begin
      row_cap[k]  = cap_q[idx][k];
      row_tick[k] = tick_q[idx][k];
    end
  end

  // Span from oldest stored edge to the arriving edge that completes the quad
  assign span      = TIME_W'(q_item_i.tick - row_tick[0]);
  assign in_window = (span <= cfg_i.window);

  // Row update and count update
  always_comb begin
    cnt_d  = cnt_q;
    row_we = 1'b0;
    for (int k = 0; k < EDGES; k++) begin
      new_cap[k]  = row_cap[k];
      new_tick[k] = row_tick[k];
    end
    if (is_clear) begin
      cnt_d = '0;
    end else if (is_edge) begin
      row_we = 1'b1;
      if (cnt_rd != EDGE_W'(EDGES - 1)) begin
        // Still filling: append at the current count
        new_cap[cnt_rd]  = q_item_i.cap;
        new_tick[cnt_rd] = q_item_i.tick;
        cnt_d[idx]       = EDGE_W'(cnt_rd + 1'b1);
      end else if (!in_window) begin
        // Too slow: drop the oldest edge, keep three
        for (int k = 0; k < EDGES - 2; k++) begin
          new_cap[k]  = row_cap[k+1];
          new_tick[k] = row_tick[k+1];
        end
        new_cap[EDGES-2]  = q_item_i.cap;
        new_tick[EDGES-2] = q_item_i.tick;
        cnt_d[idx]        = EDGE_W'(EDGES - 1);
      end else begin
        // Complete quad: evaluate and restart
        new_cap[EDGES-1]  = q_item_i.cap;
        new_tick[EDGES-1] = q_item_i.tick;
        cnt_d[idx]        = '0;
      end
    end
  end

  // Spacings for the checker
  always_comb begin
    s1_meas_d.eval      = is_edge && (cnt_rd == EDGE_W'(EDGES - 1)) && in_window;
    s1_meas_d.sensor    = q_item_i.sensor;
    s1_meas_d.intensity = TIME_W'(row_cap[1] - row_cap[0]);
    s1_meas_d.lead      = TIME_W'(row_cap[2] - row_cap[0]);
    s1_meas_d.trail     = TIME_W'(q_item_i.cap - row_cap[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (adv_i) begin
        s1_valid_q <= pop;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      for (int k = 0; k < EDGES; k++) begin
        cap_q[idx][k]  <= new_cap[k];
        tick_q[idx][k] <= new_tick[k];
      end
    end
    if (adv_i) begin
      s1_meas_q <= s1_meas_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_meas_o  = s1_meas_q;

`ifndef SYNTHESIS
  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_clear |=> cnt_q == '0)
    else $error("clear transaction left an edge count set");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_edge && (cnt_rd != EDGE_W'(EDGES - 1))
      |=> cnt_q[$past(idx)] == EDGE_W'($past(cnt_rd) + 1'b1))
    else $error("edge count did not step on a filling edge");

  a_eval_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_meas_d.eval |=> cnt_q[$past(idx)] == '0)
    else $error("evaluated quad did not restart the sensor");

  a_eval_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_meas_q.eval && !s1_valid_q |-> 1'b0 || !s1_meas_q.eval || s1_valid_q)
    else $error("evaluation flag without a transaction");
`endif

endmodule

// File: hdl/irpps_check.sv
// ----------------------------------------------------------------------------
// irpps_check
// Symbol checks, symbol quantization and the result register.
// ----------------------------------------------------------------------------
module irpps_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  irpps_pkg::cfg_t                cfg_i,
  input  logic                           s1_valid_i,
  input  irpps_pkg::meas_t               s1_meas_i,
  output logic                           adv_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           symbol_valid_o,
  output logic [irpps_pkg::SENSOR_W-1:0] symbol_sensor_o,
  output logic [irpps_pkg::TIME_W-1:0]   pulse_intensity_o,
  output logic [irpps_pkg::SYM_W-1:0]    symbol_value_o
);
  import irpps_pkg::*;

  // Stage 2 registers
  logic                 s2_valid_q;
  logic                 s2_ok_q;
  logic [SENSOR_W-1:0]  s2_sensor_q;
  logic [TIME_W-1:0]    s2_int_q;
  logic [TIME_W-1:0]    s2_lead_q;
  logic [PROD_W-1:0]    s2_prod_q;

  // Output registers
  logic                 out_valid_q;
  logic                 sym_ok_q;
  logic [SENSOR_W-1:0]  sensor_q;
  logic [TIME_W-1:0]    int_q;
  logic [SYM_W-1:0]     sym_q;

  logic                 bal_ok, int_ok, ok_d;
  logic [TIME_W-1:0]    lead_off;
  logic [QUOT_IN_W-1:0] quot_in;
  logic [PROD_W-1:0]    prod_d;
  logic [SYM_W-1:0]     sym;
  logic [TIME_W-1:0]    grid, grid_diff;
  logic                 grid_ok, sym_ok_d;

  // Whole pipe moves when the result register can be refilled
  assign adv_o = !out_valid_q || !out_stall_i;

  // Balance and intensity checks, reciprocal multiply for /28
  assign bal_ok   = (mag16(TIME_W'(s1_meas_i.trail - s1_meas_i.lead)) < {1'b0, cfg_i.bal_tol});
  assign int_ok   = (s1_meas_i.intensity >= TIME_W'(cfg_i.min_int)) &&
                    (s1_meas_i.intensity < TIME_W'(MAX_INTENSITY));
  assign ok_d     = s1_meas_i.eval && bal_ok && int_ok;
  assign lead_off = TIME_W'(s1_meas_i.lead - TIME_W'(SYM_ROUND_OFFSET));
  assign quot_in  = lead_off[TIME_W-1:DIV_PRE_SHIFT];
  assign prod_d   = PROD_W'(quot_in) * PROD_W'(RECIP_7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      s2_valid_q  <= s1_valid_i;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      s2_ok_q     <= ok_d;
      s2_sensor_q <= s1_meas_i.sensor;
      s2_int_q    <= s1_meas_i.intensity;
      s2_lead_q   <= s1_meas_i.lead;
      s2_prod_q   <= prod_d;
    end
  end

  // Grid point of the quantized symbol and distance check
  assign sym       = s2_prod_q[RECIP_SHIFT +: SYM_W];
  assign grid      = TIME_W'(TIME_W'(sym) * TIME_W'(SYM_GAIN) + TIME_W'(SYM_OFFSET));
  assign grid_diff = TIME_W'(s2_lead_q - grid);
  assign grid_ok   = (mag16(grid_diff) < {1'b0, cfg_i.sym_tol});
  assign sym_ok_d  = s2_ok_q && grid_ok;

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      sym_ok_q <= sym_ok_d;
      sensor_q <= s2_sensor_q;
      int_q    <= s2_int_q;
      sym_q    <= sym;
    end
  end

  // Rejected or non-symbol transactions report all zero
  assign out_valid_o       = out_valid_q;
  assign symbol_valid_o    = sym_ok_q;
  assign symbol_sensor_o   = sym_ok_q ? sensor_q : '0;
  assign pulse_intensity_o = sym_ok_q ? int_q    : '0;
  assign symbol_value_o    = sym_ok_q ? sym_q    : '0;

`ifndef SYNTHESIS
  a_ok_needs_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_o && ok_d |=> s2_ok_q && $past(s1_meas_i.eval))
    else $error("symbol checks passed without a complete quad");

  a_sym_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && sym_ok_q |-> sym_q <= SYM_W'(2340))
    else $error("symbol value out of range");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> $stable(symbol_value_o) && $stable(symbol_valid_o) &&
      $stable(pulse_intensity_o))
    else $error("result register changed while stalled");
`endif

endmodule

// File: hdl/ir_pulse_pair_symbol_decoder_core.sv
// ----------------------------------------------------------------------------
// ir_pulse_pair_symbol_decoder_core
// Top level: configuration registers, front queue, edge tracker, checker.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one edge capture or a
//   clear command per transaction. Output channel (out_valid_o / out_stall_i)
//   returns exactly one result per input transaction, in order; results that
//   are not a decoded symbol are all zero.
//   Throughput: one transaction per cycle while the receiver does not stall;
//   the per-sensor edge rows are read, updated and written back in the same
//   cycle, so back-to-back edges of the same sensor need no forwarding.
//   An accepted input passes the queue, the edge tracker, the check stage and
//   the result register. A two-entry queue sits between the front and the
//   back; in_stall_o rises only when it is full. When the receiver stalls a
//   valid result, the result register holds and the back pipeline freezes;
//   the front keeps filling the queue. Reset clears all edge counts, the
//   queue and the pipeline valids, and loads the register defaults. Edge rows
//   hold no reset value. The user writes configuration (cfg_we_i, cfg_idx_i,
//   cfg_data_i) only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ir_pulse_pair_symbol_decoder_core #(
  parameter int unsigned NUM_SENSORS = irpps_pkg::DEF_NUM_SENSORS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [irpps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [irpps_pkg::CFG_DW-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [irpps_pkg::SENSOR_W-1:0]  sensor_i,
  input  logic [irpps_pkg::TIME_W-1:0]    capture_time_i,
  input  logic [irpps_pkg::TIME_W-1:0]    tick_time_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            symbol_valid_o,
  output logic [irpps_pkg::SENSOR_W-1:0]  symbol_sensor_o,
  output logic [irpps_pkg::TIME_W-1:0]    pulse_intensity_o,
  output logic [irpps_pkg::SYM_W-1:0]     symbol_value_o
);
  import irpps_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  q_valid, q_pop, adv, s1_valid;
  item_t q_item;
  meas_t s1_meas;

  // Configuration register file
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW:  cfg_d.window  = cfg_data_i;
        REG_MIN_INT: cfg_d.min_int = cfg_data_i[MINI_W-1:0];
        REG_BAL_TOL: cfg_d.bal_tol = cfg_data_i[TOL_W-1:0];
        REG_SYM_TOL: cfg_d.sym_tol = cfg_data_i[TOL_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window  <= RST_WINDOW;
      cfg_q.min_int <= RST_MIN_INT;
      cfg_q.bal_tol <= RST_BAL_TOL;
      cfg_q.sym_tol <= RST_SYM_TOL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  irpps_front #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .sensor_i       (sensor_i),
    .capture_time_i (capture_time_i),
    .tick_time_i    (tick_time_i),
    .q_valid_o      (q_valid),
    .q_item_o       (q_item),
    .q_pop_i        (q_pop)
  );

  irpps_track #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .adv_i      (adv),
    .s1_valid_o (s1_valid),
    .s1_meas_o  (s1_meas)
  );

  irpps_check u_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .s1_valid_i        (s1_valid),
    .s1_meas_i         (s1_meas),
    .adv_o             (adv),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .symbol_valid_o    (symbol_valid_o),
    .symbol_sensor_o   (symbol_sensor_o),
    .pulse_intensity_o (pulse_intensity_o),
    .symbol_value_o    (symbol_value_o)
  );

endmodule
